// File: design/ctrs_pkg.sv
`timescale 1ns / 1ps

package ctrs_pkg;

  localparam int LEAVES  = 1024;
  localparam int LVL_W   = $clog2(LEAVES);
  localparam int NODE_W  = LVL_W + 1;
  localparam int DEPTH   = 2 * LEAVES;
  localparam int CNT_W   = 32;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int DELTA_W = 17;
  localparam int STAT_W  = 2;
  localparam int SUM_W   = CNT_W + 2;

  localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);
  localparam logic [NODE_W-1:0] NODE_LEAF0 = NODE_W'(LEAVES);

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_RANGE  = 2'd1,
    OP_SELECT = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_BAD_RANK  = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_CHK,
    ST_UPD_WALK,
    ST_RNG,
    ST_RNG_DRAIN,
    ST_SEL_CHK,
    ST_SEL_WALK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [NODE_W-1:0] ra_a;
    logic [NODE_W-1:0] ra_b;
  } mem_req_t;

endpackage

// File: design/ctrs_if.sv
`timescale 1ns / 1ps

interface ctrs_req_if;
  import ctrs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [IDX_W-1:0]          index;
  logic [IDX_W-1:0]          upper_index;
  logic signed [DELTA_W-1:0] delta;
  logic [CNT_W-1:0]          rank;

  modport source (output valid, operation, index, upper_index, delta, rank, input ready);
  modport sink (input valid, operation, index, upper_index, delta, rank, output ready);
endinterface

interface ctrs_rsp_if;
  import ctrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  total;
  logic [IDX_W-1:0]  position;

  modport source (output valid, status, total, position, input ready);
  modport sink (input valid, status, total, position, output ready);
endinterface

// File: design/ctrs_mem.sv
`timescale 1ns / 1ps

module ctrs_mem (
  input  logic                         clk_i,
  input  ctrs_pkg::mem_req_t           req_i,
  output logic [ctrs_pkg::CNT_W-1:0]   rd_a_o,
  output logic [ctrs_pkg::CNT_W-1:0]   rd_b_o
);
  import ctrs_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rd_a_q;
  logic [CNT_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem[req_i.ra_a];
    rd_b_q <= mem[req_i.ra_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// File: design/counting_tree_rank_select_top.sv
`timescale 1ns / 1ps
// Update passes a check state and a leaf-to-root walk, select a check state and a
// root-to-leaf walk, range sum a level walk and a drain state; bad index, range or
// operation go straight to the result state, overflow and bad rank from the check state.
// Throughput: one item at a time, one tree level per cycle through the registered read
// ports of the node memory; the next input beat is taken when the result beat first can be.
// Reset: a clearing pass zeroes all 2*LEAVES nodes before any input beat.

module counting_tree_rank_select_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctrs_req_if.sink   req_i,
  ctrs_rsp_if.source rsp_o
);
  import ctrs_pkg::*;

  state_e state_q, state_d;

  logic [NODE_W-1:0]  clr_q, clr_d;
  logic               rsp_vld_q, rsp_vld_d;
  logic [STAT_W-1:0]  rsp_status_q, rsp_status_d;
  logic [CNT_W-1:0]   rsp_total_q, rsp_total_d;
  logic [IDX_W-1:0]   rsp_pos_q, rsp_pos_d;

  logic [CNT_W-1:0]          rank_q, rank_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic [NODE_W-1:0]         wa_q, wa_d;
  logic [NODE_W-1:0]         l_q, l_d;
  logic [NODE_W-1:0]         r_q, r_d;
  logic [NODE_W-1:0]         v_q, v_d;
  logic [CNT_W-1:0]          lo_q, lo_d;
  logic [CNT_W-1:0]          acc_q, acc_d;
  logic                      pa_q, pa_d;
  logic                      pb_q, pb_d;
  status_e                   res_status_q, res_status_d;
  logic [CNT_W-1:0]          res_total_q, res_total_d;
  logic [IDX_W-1:0]          res_pos_q, res_pos_d;

  mem_req_t         mem_req;
  logic [CNT_W-1:0] rd_a;
  logic [CNT_W-1:0] rd_b;

  ctrs_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd_a_o(rd_a),
    .rd_b_o(rd_b)
  );

  logic              req_fire;
  logic              slot_free;
  logic              idx_bad;
  logic              rng_bad;
  logic [NODE_W-1:0] leaf_pos;
  logic [NODE_W-1:0] upper_pos;
  logic [SUM_W-1:0]  leaf_new;
  logic [SUM_W-1:0]  root_new;
  logic              upd_bad;
  logic [CNT_W-1:0]  add;
  logic              sel_bad;
  logic              go_left;
  logic [NODE_W-1:0] vn;
  logic              vn_leaf;
  logic              rng_lt;
  logic              rng_eq;
  logic [CNT_W-1:0]  acc_sum;
  logic              walk_top;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !rsp_vld_q || rsp_o.ready;

  assign idx_bad   = 32'(req_i.index) >= 32'(LEAVES);
  assign rng_bad   = (32'(req_i.upper_index) >= 32'(LEAVES)) ||
                     (req_i.index > req_i.upper_index);
  assign leaf_pos  = NODE_LEAF0 + NODE_W'(req_i.index);
  assign upper_pos = NODE_LEAF0 + NODE_W'(req_i.upper_index);

  assign leaf_new = SUM_W'(rd_a) + SUM_W'(delta_q);
  assign root_new = SUM_W'(rd_b) + SUM_W'(delta_q);
  assign upd_bad  = leaf_new[SUM_W-1] || (root_new[SUM_W-1:CNT_W] == 2'b01);
  assign add      = CNT_W'(delta_q);
  assign walk_top = (wa_q == NODE_ROOT);

  assign sel_bad = (rank_q == '0) || (rank_q > rd_b);
  assign go_left = rd_a > lo_q;
  assign vn      = NODE_W'({v_q, !go_left});
  assign vn_leaf = vn[LVL_W];

  assign rng_lt  = l_q < r_q;
  assign rng_eq  = l_q == r_q;
  assign acc_sum = acc_q + (pa_q ? rd_a : '0) + (pb_q ? rd_b : '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_fire) begin
          unique case (op_e'(req_i.operation))
            OP_UPDATE: state_d = idx_bad ? ST_RESP : ST_UPD_CHK;
            OP_RANGE:  state_d = rng_bad ? ST_RESP : ST_RNG;
            OP_SELECT: state_d = ST_SEL_CHK;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_UPD_CHK: begin
        state_d = upd_bad ? ST_RESP : ST_UPD_WALK;
      end
      ST_UPD_WALK: begin
        if (walk_top) state_d = ST_RESP;
      end
      ST_RNG: begin
        if (!rng_lt) state_d = ST_RNG_DRAIN;
      end
      ST_RNG_DRAIN: begin
        state_d = ST_RESP;
      end
      ST_SEL_CHK: begin
        state_d = sel_bad ? ST_RESP : ST_SEL_WALK;
      end
      ST_SEL_WALK: begin
        if (vn_leaf) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_total_d  = rsp_total_q;
    rsp_pos_d    = rsp_pos_q;
    rank_d       = rank_q;
    delta_d      = delta_q;
    wa_d         = wa_q;
    l_d          = l_q;
    r_d          = r_q;
    v_d          = v_q;
    lo_d         = lo_q;
    acc_d        = acc_q;
    pa_d         = pa_q;
    pb_d         = pb_q;
    res_status_d = res_status_q;
    res_total_d  = res_total_q;
    res_pos_d    = res_pos_q;
    mem_req      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_q;
        clr_d         = clr_q + NODE_W'(1);
      end
      ST_IDLE: begin
        if (req_fire) begin
          rank_d       = req_i.rank;
          delta_d      = req_i.delta;
          wa_d         = leaf_pos;
          l_d          = leaf_pos;
          r_d          = upper_pos;
          acc_d        = '0;
          pa_d         = 1'b0;
          pb_d         = 1'b0;
          res_status_d = STATUS_OK;
          res_total_d  = '0;
          res_pos_d    = '0;
          unique case (op_e'(req_i.operation))
            OP_UPDATE: begin
              mem_req.ra_a = leaf_pos;
              mem_req.ra_b = NODE_ROOT;
              if (idx_bad) res_status_d = STATUS_BAD_INDEX;
            end
            OP_RANGE: begin
              if (rng_bad) res_status_d = STATUS_BAD_INDEX;
            end
            OP_SELECT: begin
              mem_req.ra_b = NODE_ROOT;
            end
            default: res_status_d = STATUS_BAD_INDEX;
          endcase
        end
      end
      ST_UPD_CHK: begin
        if (upd_bad) begin
          res_status_d = STATUS_OVERFLOW;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wa_q;
          mem_req.wdata = rd_a + add;
          mem_req.ra_a  = wa_q >> 1;
          wa_d          = wa_q >> 1;
        end
      end
      ST_UPD_WALK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wa_q;
        mem_req.wdata = rd_a + add;
        if (!walk_top) begin
          mem_req.ra_a = wa_q >> 1;
          wa_d         = wa_q >> 1;
        end
      end
      ST_RNG: begin
        acc_d = acc_sum;
        if (rng_lt) begin
          mem_req.ra_a = l_q;
          mem_req.ra_b = r_q;
          pa_d         = l_q[0];
          pb_d         = !r_q[0];
          l_d          = (l_q + NODE_W'(1)) >> 1;
          r_d          = (r_q - NODE_W'(1)) >> 1;
        end else if (rng_eq) begin
          mem_req.ra_a = l_q;
          pa_d         = 1'b1;
          pb_d         = 1'b0;
        end else begin
          pa_d = 1'b0;
          pb_d = 1'b0;
        end
      end
      ST_RNG_DRAIN: begin
        res_total_d = acc_sum;
      end
      ST_SEL_CHK: begin
        if (sel_bad) begin
          res_status_d = STATUS_BAD_RANK;
        end else begin
          lo_d         = rank_q - CNT_W'(1);
          v_d          = NODE_ROOT;
          mem_req.ra_a = NODE_ROOT << 1;
        end
      end
      ST_SEL_WALK: begin
        if (!go_left) lo_d = lo_q - rd_a;
        if (vn_leaf) begin
          res_pos_d = IDX_W'(vn[LVL_W-1:0]);
        end else begin
          v_d          = vn;
          mem_req.ra_a = vn << 1;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          rsp_vld_d    = 1'b1;
          rsp_status_d = res_status_q;
          rsp_total_d  = res_total_q;
          rsp_pos_d    = res_pos_q;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_status_q <= rsp_status_d;
    rsp_total_q  <= rsp_total_d;
    rsp_pos_q    <= rsp_pos_d;
    rank_q       <= rank_d;
    delta_q      <= delta_d;
    wa_q         <= wa_d;
    l_q          <= l_d;
    r_q          <= r_d;
    v_q          <= v_d;
    lo_q         <= lo_d;
    acc_q        <= acc_d;
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    res_status_q <= res_status_d;
    res_total_q  <= res_total_d;
    res_pos_q    <= res_pos_d;
  end

  assign rsp_o.valid    = rsp_vld_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.total    = rsp_total_q;
  assign rsp_o.position = rsp_pos_q;

endmodule

// File: design/ctrs_chk.sv
`timescale 1ns / 1ps

module ctrs_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ctrs_pkg::STAT_W-1:0]   rsp_status_i,
  input logic [ctrs_pkg::CNT_W-1:0]    rsp_total_i,
  input logic [ctrs_pkg::IDX_W-1:0]    rsp_position_i
);
  import ctrs_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_total_i) && $stable(rsp_position_i))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("input beat taken while an item is in flight");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STATUS_OK) |->
      (rsp_total_i == '0) && (rsp_position_i == '0))
    else $error("error result carries nonzero payload");

  a_clear_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |=> !req_ready_i && !rsp_valid_i)
    else $error("input beat possible before clearing pass ends");

endmodule

bind counting_tree_rank_select_top ctrs_chk u_ctrs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_total_i   (rsp_o.total),
  .rsp_position_i(rsp_o.position)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ctrs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_BEATS = 1500;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int DELTA_MAX = 65535;
  localparam int DELTA_MIN = -65536;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] total;
    logic [IDX_W-1:0] position;
  } answer_t;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic [IDX_W-1:0]          lo;
    logic [IDX_W-1:0]          hi;
    logic signed [DELTA_W-1:0] delta;
    logic [CNT_W-1:0]          rank;
    bit                        fixed;
    answer_t                   known;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #6 clk_i = ~clk_i;

  ctrs_req_if req_if ();
  ctrs_rsp_if rsp_if ();

  counting_tree_rank_select_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [CNT_W-1:0] tree_cnt [DEPTH];
  answer_t          answers_due [$];
  int               busy_leaves [$];
  beat_t            plan [$];

  int  mismatches = 0;
  int  beats_sent = 0;
  int  results_checked = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  bit  calm = 1'b0;
  bit  idle_on = 1'b1;

  function automatic beat_t mk_beat(logic [OP_W-1:0] op, int lo, int hi, int delta,
                                    logic [CNT_W-1:0] rank);
    beat_t b;
    b.op    = op;
    b.lo    = IDX_W'(lo);
    b.hi    = IDX_W'(hi);
    b.delta = DELTA_W'(delta);
    b.rank  = rank;
    b.fixed = 1'b0;
    b.known = '{STATUS_OK, '0, '0};
    return b;
  endfunction

  function automatic beat_t pinned(beat_t b, status_e st, logic [CNT_W-1:0] total, int leaf);
    b.fixed = 1'b1;
    b.known = '{st, total, IDX_W'(leaf)};
    return b;
  endfunction

  function automatic void add_row(beat_t b);
    plan = {plan, b};
  endfunction

  function automatic answer_t apply_to_tree(beat_t b);
    answer_t a;
    int      node;
    int      l;
    int      r;
    longint  leaf_next;
    longint  root_next;
    longint  acc;
    longint  left_over;
    a = '{STATUS_OK, '0, '0};
    case (b.op)
      OP_UPDATE: begin
        if (int'(b.lo) >= LEAVES) begin
          a.status = STATUS_BAD_INDEX;
        end else begin
          node = LEAVES + int'(b.lo);
          leaf_next = longint'({1'b0, tree_cnt[node]}) + longint'(b.delta);
          root_next = longint'({1'b0, tree_cnt[1]}) + longint'(b.delta);
          if (leaf_next < 0 || root_next > longint'({1'b0, CNT_MAX})) begin
            a.status = STATUS_OVERFLOW;
          end else begin
            while (node != 0) begin
              tree_cnt[node] = tree_cnt[node] + CNT_W'(b.delta);
              node = node >> 1;
            end
          end
        end
      end
      OP_RANGE: begin
        if (int'(b.hi) >= LEAVES || b.lo > b.hi) begin
          a.status = STATUS_BAD_INDEX;
        end else begin
          l = LEAVES + int'(b.lo);
          r = LEAVES + int'(b.hi);
          acc = 0;
          while (l < r) begin
            if (l[0]) acc += longint'({1'b0, tree_cnt[l]});
            if (!r[0]) acc += longint'({1'b0, tree_cnt[r]});
            l = (l + 1) >> 1;
            r = (r - 1) >> 1;
          end
          if (l == r) acc += longint'({1'b0, tree_cnt[l]});
          a.total = acc[CNT_W-1:0];
        end
      end
      OP_SELECT: begin
        if (b.rank == '0 || b.rank > tree_cnt[1]) begin
          a.status = STATUS_BAD_RANK;
        end else begin
          left_over = longint'({1'b0, b.rank}) - 1;
          node = 1;
          while (node < LEAVES) begin
            if (longint'({1'b0, tree_cnt[2*node]}) > left_over) begin
              node = 2 * node;
            end else begin
              left_over -= longint'({1'b0, tree_cnt[2*node]});
              node = 2 * node + 1;
            end
          end
          a.position = IDX_W'(node - LEAVES);
        end
      end
      default: a.status = STATUS_BAD_INDEX;
    endcase
    return a;
  endfunction

  function automatic beat_t random_beat();
    int          pick;
    int          leaf;
    int          lo;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    leaf = $urandom_range(0, LEAVES - 1);
    if (busy_leaves.size() > 0 && $urandom_range(0, 1)) begin
      leaf = busy_leaves[$urandom_range(0, busy_leaves.size() - 1)];
    end
    v = tree_cnt[LEAVES + leaf];
    lo = $urandom_range(0, LEAVES - 1);
    if (pick < 50 && pick >= 35 && v != 0) begin
      return mk_beat(OP_UPDATE, leaf, $urandom_range(0, LEAVES - 1),
                     -int'($urandom_range(1, (v > 65536) ? 65536 : v)), $urandom);
    end else if (pick < 50) begin
      return mk_beat(OP_UPDATE, leaf, $urandom_range(0, LEAVES - 1),
                     $urandom_range(0, DELTA_MAX), $urandom);
    end else if (pick < 70) begin
      return mk_beat(OP_RANGE, lo, $urandom_range(lo, LEAVES - 1), $urandom, $urandom);
    end else if (pick < 90) begin
      return mk_beat(OP_SELECT, lo, $urandom_range(0, LEAVES - 1), $urandom,
                     (tree_cnt[1] == '0) ? 32'd1 : $urandom_range(1, tree_cnt[1]));
    end
    case ($urandom_range(0, 4))
      0: return mk_beat(OP_UNKNOWN, lo, $urandom, $urandom, $urandom);
      1: return mk_beat(OP_RANGE, (lo == 0) ? 1 : lo, $urandom_range(0, (lo == 0) ? 0 : lo - 1),
                        $urandom, $urandom);
      2: return mk_beat(OP_SELECT, lo, $urandom, $urandom, '0);
      3: return mk_beat(OP_SELECT, lo, $urandom, $urandom, $urandom);
      default: return mk_beat(OP_UPDATE, leaf, $urandom,
                              (v < 65536) ? -int'(v) - 1 : DELTA_MIN, $urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_beat(input beat_t b);
    int      gap;
    answer_t predicted;
    gap = 0;
    if (idle_on && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= b.op;
    req_if.index       <= b.lo;
    req_if.upper_index <= b.hi;
    req_if.delta       <= b.delta;
    req_if.rank        <= b.rank;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = apply_to_tree(b);
    if (b.op == OP_UPDATE && predicted.status == STATUS_OK && b.delta > 0) begin
      busy_leaves = {busy_leaves, int'(b.lo)};
    end
    answers_due = {answers_due, (b.fixed ? b.known : predicted)};
    beats_sent++;
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (answers_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result, status %0d", rsp_if.status));
      end else begin
        want = answers_due.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (rsp_if.status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
        if (rsp_if.total !== want.total)
          note_mismatch($sformatf("total %0d, want %0d", rsp_if.total, want.total));
        if (rsp_if.position !== want.position)
          note_mismatch($sformatf("position %0d, want %0d", rsp_if.position, want.position));
      end
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 48)) @(posedge clk_i);
      if (idle_on && !calm) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int i;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_UPDATE;
    req_if.index       <= '0;
    req_if.upper_index <= '0;
    req_if.delta       <= '0;
    req_if.rank        <= '0;
    for (i = 0; i < DEPTH; i++) tree_cnt[i] = '0;

    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 1), STATUS_BAD_RANK, 0, 0));
    add_row(pinned(mk_beat(OP_RANGE, 0, 1023, 0, 0), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_UPDATE, 0, 0, -1, 0), STATUS_OVERFLOW, 0, 0));
    add_row(pinned(mk_beat(OP_UNKNOWN, 0, 0, 0, 0), STATUS_BAD_INDEX, 0, 0));
    add_row(pinned(mk_beat(OP_RANGE, 5, 4, 0, 0), STATUS_BAD_INDEX, 0, 0));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 0), STATUS_BAD_RANK, 0, 0));
    add_row(pinned(mk_beat(OP_UPDATE, 1023, 0, DELTA_MAX, 0), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_UPDATE, 0, 0, DELTA_MAX, 0), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_UPDATE, 512, 0, DELTA_MIN, 0), STATUS_OVERFLOW, 0, 0));
    add_row(pinned(mk_beat(OP_UPDATE, 511, 0, 1, 0), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 1), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 65535), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 65536), STATUS_OK, 0, 511));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 65537), STATUS_OK, 0, 1023));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 131071), STATUS_OK, 0, 1023));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, 131072), STATUS_BAD_RANK, 0, 0));
    add_row(pinned(mk_beat(OP_SELECT, 0, 0, 0, CNT_MAX), STATUS_BAD_RANK, 0, 0));
    add_row(pinned(mk_beat(OP_RANGE, 0, 1023, 0, 0), STATUS_OK, 131071, 0));
    add_row(pinned(mk_beat(OP_RANGE, 1023, 1023, 0, 0), STATUS_OK, 65535, 0));
    add_row(pinned(mk_beat(OP_RANGE, 1, 1022, 0, 0), STATUS_OK, 1, 0));
    add_row(pinned(mk_beat(OP_UPDATE, 0, 0, -65535, 0), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_RANGE, 0, 0, 0, 0), STATUS_OK, 0, 0));
    add_row(pinned(mk_beat(OP_RANGE, 1023, 0, 0, 0), STATUS_BAD_INDEX, 0, 0));
    add_row(mk_beat(OP_UPDATE, 300, 0, 12345, 0));
    add_row(mk_beat(OP_RANGE, 200, 700, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) send_beat(plan[k]);

    for (i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 200 == 0) idle_on = $urandom_range(0, 3) != 0;
      send_beat(random_beat());
    end

    // no idling from here on
    calm = 1'b1;
    send_beat(pinned(mk_beat(OP_SELECT, 0, 0, 0, CNT_MAX), STATUS_BAD_RANK, 0, 0));
    for (i = 0; i < 40; i++) send_beat(random_beat());

    req_if.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("%0d requests, %0d results checked; root count %0d", beats_sent,
             results_checked, tree_cnt[1]);
    $display("status counts ok/index/rank/overflow: %0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
design/ctrs_pkg.sv
design/ctrs_if.sv
design/ctrs_mem.sv
design/counting_tree_rank_select_top.sv
design/ctrs_chk.sv
verif/tb.sv
